// ----- hdl/ifs_cg_pkg.sv -----
// ifs_cg_pkg: shared widths, codes and control types of the chaos-game step core.
// No dependencies; compiled first.
package ifs_cg_pkg;

  localparam int ENTRY_W       = 3;   // entry_index and chosen_index
  localparam int WEIGHT_W      = 10;  // weight and random_draw
  localparam int COUNT_W       = 4;   // map_count register
  localparam int STATUS_W      = 2;
  localparam int FRAC_BITS     = 16;  // Q8.16 fraction
  localparam int COEFS_PER_MAP = 6;

  // word slots inside one stored map row
  localparam int SLOT_XA = 0;
  localparam int SLOT_XB = 1;
  localparam int SLOT_XC = 2;
  localparam int SLOT_YA = 3;
  localparam int SLOT_YB = 4;
  localparam int SLOT_YC = 5;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NORMAL = 2'd0,
    STATUS_BEYOND = 2'd1,
    STATUS_EMPTY  = 2'd2
  } status_t;

  // multiplier selects: xa*x, xb*y, ya*x, yb*y
  localparam logic [1:0] MSEL_XA = 2'd0;
  localparam logic [1:0] MSEL_XB = 2'd1;
  localparam logic [1:0] MSEL_YA = 2'd2;
  localparam logic [1:0] MSEL_YB = 2'd3;

  // sequencer to shared multiply/accumulate unit
  typedef struct packed {
    logic       mul;      // load product register
    logic [1:0] mul_sel;  // operand pair
    logic       acc_ld;   // first product of a pair into accumulator
    logic       acc_add;  // add second product plus rounding half
    logic       fin;      // shift, add offset, clamp, store
    logic       fin_y;    // finishing y (else x)
  } mac_ctrl_t;

endpackage

// ----- hdl/ifs_cg_in_if.sv -----
// ifs_cg_in_if: input item channel (load or step) with valid/ready.
// Uses ifs_cg_pkg for field widths.
interface ifs_cg_in_if #(
  parameter int WORD_WIDTH = 24
);
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [ifs_cg_pkg::ENTRY_W-1:0]     entry_index;
  logic signed [WORD_WIDTH-1:0]       coef_xa;
  logic signed [WORD_WIDTH-1:0]       coef_xb;
  logic signed [WORD_WIDTH-1:0]       coef_xc;
  logic signed [WORD_WIDTH-1:0]       coef_ya;
  logic signed [WORD_WIDTH-1:0]       coef_yb;
  logic signed [WORD_WIDTH-1:0]       coef_yc;
  logic [ifs_cg_pkg::WEIGHT_W-1:0]    weight;
  logic [ifs_cg_pkg::WEIGHT_W-1:0]    random_draw;
  logic signed [WORD_WIDTH-1:0]       point_x;
  logic signed [WORD_WIDTH-1:0]       point_y;

  modport source (
    output valid, kind, entry_index, coef_xa, coef_xb, coef_xc,
           coef_ya, coef_yb, coef_yc, weight, random_draw, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_index, coef_xa, coef_xb, coef_xc,
           coef_ya, coef_yb, coef_yc, weight, random_draw, point_x, point_y,
    output ready
  );
endinterface

// ----- hdl/ifs_cg_out_if.sv -----
// ifs_cg_out_if: result item channel with valid/ready.
// Uses ifs_cg_pkg for field widths.
interface ifs_cg_out_if #(
  parameter int WORD_WIDTH = 24
);
  logic                               valid;
  logic                               ready;
  logic signed [WORD_WIDTH-1:0]       new_x;
  logic signed [WORD_WIDTH-1:0]       new_y;
  logic [ifs_cg_pkg::ENTRY_W-1:0]     chosen_index;
  logic [ifs_cg_pkg::STATUS_W-1:0]    status;
  logic                               saturated;

  modport source (
    output valid, new_x, new_y, chosen_index, status, saturated,
    input  ready
  );
  modport sink (
    input  valid, new_x, new_y, chosen_index, status, saturated,
    output ready
  );
endinterface

// ----- hdl/ifs_cg_top.sv -----
// Chaos-game step core: load items write a map, step items walk the weights
// and apply the chosen affine map. A step runs through the walk, fetch and
// multiply states to done, then into the result register; the weight walk
// does one add and compare a cycle, and four products share one multiplier.
// A new item is taken only in idle, once the previous step is through. With
// no maps a step goes straight to done. rst_n is synchronous.
module ifs_chaos_game_point_step_core #(
  parameter int MAX_MAPS   = 8,
  parameter int WORD_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ifs_cg_pkg::COUNT_W-1:0]     cfg_data,
  ifs_cg_in_if.sink                          in_item,
  ifs_cg_out_if.source                       out_item
);
  localparam int WW    = WORD_WIDTH;
  localparam int IDX_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
  localparam int CMP_W = ifs_cg_pkg::COUNT_W + 1;   // holds MAX_MAPS up to 31
  localparam int SUM_W = ifs_cg_pkg::WEIGHT_W + CMP_W;
  localparam int ROW_W = ifs_cg_pkg::COEFS_PER_MAP * WW;
  localparam logic [2:0] MK_LAST = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FETCH,
    S_MUL,
    S_DONE
  } state_t;

  state_t                               state_r, state_nxt;
  logic [ifs_cg_pkg::COUNT_W-1:0]       map_count_r;
  logic [CMP_W-1:0]                     cnt;

  // step item context
  logic [ifs_cg_pkg::WEIGHT_W-1:0]      draw_r;
  logic signed [WW-1:0]                 px_r, py_r;
  logic [SUM_W-1:0]                     sum_r, sum_new;
  logic [IDX_W-1:0]                     walk_idx_r, chosen_r;
  ifs_cg_pkg::status_t                  status_r;
  logic [2:0]                           mk_r;
  logic                                 hit, last;

  // result register
  logic                                 out_valid_r;
  logic signed [WW-1:0]                 new_x_r, new_y_r;
  logic [ifs_cg_pkg::ENTRY_W-1:0]       chosen_out_r;
  logic [ifs_cg_pkg::STATUS_W-1:0]      status_out_r;
  logic                                 sat_out_r;

  logic                                 in_fire, load_fire, step_fire;
  logic                                 out_free;
  logic                                 wr_en;
  logic [ifs_cg_pkg::WEIGHT_W-1:0]      wt_data;
  logic [ROW_W-1:0]                     wr_row, rd_row;
  ifs_cg_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [WW-1:0]                 mac_x, mac_y;
  logic                                 mac_sat;

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign in_item.ready = (state_r == S_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;
  assign load_fire     = in_fire && (in_item.kind == ifs_cg_pkg::KIND_LOAD);
  assign step_fire     = in_fire && (in_item.kind == ifs_cg_pkg::KIND_STEP);
  // result register can take a new item once the old one is gone or leaving
  assign out_free      = !out_valid_r || out_item.ready;

  // count above MAX_MAPS acts as MAX_MAPS
  assign cnt = (CMP_W'(map_count_r) > CMP_W'(MAX_MAPS)) ? CMP_W'(MAX_MAPS)
                                                          : CMP_W'(map_count_r);

  // loads past the store depth are dropped
  assign wr_en  = load_fire && (CMP_W'(in_item.entry_index) < CMP_W'(MAX_MAPS));
  assign wr_row = {in_item.coef_yc, in_item.coef_yb, in_item.coef_ya,
                   in_item.coef_xc, in_item.coef_xb, in_item.coef_xa};

  // ---------------------------------------------------------------------
  // Weight walk: one weight added and compared per cycle
  // ---------------------------------------------------------------------
  assign sum_new = sum_r + SUM_W'(wt_data);
  assign hit     = sum_new >= SUM_W'(draw_r);
  assign last    = CMP_W'(walk_idx_r) == (cnt - CMP_W'(1));

  // ---------------------------------------------------------------------
  // Multiply schedule over mk 0..5:
  //   0..3 products xa*x, xb*y, ya*x, yb*y
  //   1,3  first product of a pair to accumulator; 2,4 pair sum + half
  //   3,5  round, add offset, clamp for x then y
  // ---------------------------------------------------------------------
  always_comb begin
    mac_ctrl         = '0;
    if (state_r == S_MUL) begin
      mac_ctrl.mul     = (mk_r <= 3'd3);
      mac_ctrl.mul_sel = mk_r[1:0];
      mac_ctrl.acc_ld  = (mk_r == 3'd1) || (mk_r == 3'd3);
      mac_ctrl.acc_add = (mk_r == 3'd2) || (mk_r == 3'd4);
      mac_ctrl.fin     = (mk_r == 3'd3) || (mk_r == MK_LAST);
      mac_ctrl.fin_y   = (mk_r == MK_LAST);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (step_fire) begin
          state_nxt = (cnt == '0) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (hit || last) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_MUL;
      S_MUL: begin
        if (mk_r == MK_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      map_count_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        map_count_r <= cfg_data;
      end

      if (step_fire) begin
        draw_r     <= in_item.random_draw;
        px_r       <= in_item.point_x;
        py_r       <= in_item.point_y;
        sum_r      <= '0;
        walk_idx_r <= '0;
        chosen_r   <= '0;
        mk_r       <= '0;
        status_r   <= (cnt == '0) ? ifs_cg_pkg::STATUS_EMPTY
                                  : ifs_cg_pkg::STATUS_NORMAL;
      end

      if (state_r == S_WALK) begin
        sum_r      <= sum_new;
        walk_idx_r <= walk_idx_r + IDX_W'(1);
        if (hit) begin
          chosen_r <= walk_idx_r;
          status_r <= ifs_cg_pkg::STATUS_NORMAL;
        end else if (last) begin
          chosen_r <= walk_idx_r;
          status_r <= ifs_cg_pkg::STATUS_BEYOND;
        end
      end

      if (state_r == S_MUL) begin
        mk_r <= mk_r + 3'd1;
      end

      // result register
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r  <= 1'b1;
        chosen_out_r <= ifs_cg_pkg::ENTRY_W'(chosen_r);
        status_out_r <= status_r;
        if (status_r == ifs_cg_pkg::STATUS_EMPTY) begin
          new_x_r   <= '0;
          new_y_r   <= '0;
          sat_out_r <= 1'b0;
        end else begin
          new_x_r   <= mac_x;
          new_y_r   <= mac_y;
          sat_out_r <= mac_sat;
        end
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.new_x        = new_x_r;
  assign out_item.new_y        = new_y_r;
  assign out_item.chosen_index = chosen_out_r;
  assign out_item.status       = status_out_r;
  assign out_item.saturated    = sat_out_r;

  // ---------------------------------------------------------------------
  // Map store and shared multiply unit
  // ---------------------------------------------------------------------
  ifs_cg_map_store #(
    .MAX_MAPS   (MAX_MAPS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (IDX_W'(in_item.entry_index)),
    .wr_row    (wr_row),
    .wr_weight (in_item.weight),
    .wt_addr   (walk_idx_r),
    .wt_data   (wt_data),
    .rd_en     (state_r == S_FETCH),
    .rd_addr   (chosen_r),
    .rd_row    (rd_row)
  );

  ifs_cg_mac #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .coef_row (rd_row),
    .point_x  (px_r),
    .point_y  (py_r),
    .res_x    (mac_x),
    .res_y    (mac_y),
    .sat      (mac_sat)
  );

endmodule

// ----- hdl/ifs_cg_map_store.sv -----
// ifs_cg_map_store: map coefficient row memory and weight registers.
// Uses ifs_cg_pkg.
module ifs_cg_map_store #(
  parameter int MAX_MAPS   = 8,
  parameter int WORD_WIDTH = 24
) (
  input  logic                                                clk,
  input  logic                                                wr_en,
  input  logic [((MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1)-1:0]  wr_addr,
  input  logic [ifs_cg_pkg::COEFS_PER_MAP*WORD_WIDTH-1:0]     wr_row,
  input  logic [ifs_cg_pkg::WEIGHT_W-1:0]                     wr_weight,
  input  logic [((MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1)-1:0]  wt_addr,
  output logic [ifs_cg_pkg::WEIGHT_W-1:0]                     wt_data,
  input  logic                                                rd_en,
  input  logic [((MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1)-1:0]  rd_addr,
  output logic [ifs_cg_pkg::COEFS_PER_MAP*WORD_WIDTH-1:0]     rd_row
);
  localparam int ROW_W = ifs_cg_pkg::COEFS_PER_MAP * WORD_WIDTH;

  logic [ROW_W-1:0]                 row_mem [MAX_MAPS];
  logic [ifs_cg_pkg::WEIGHT_W-1:0]  weight_r [MAX_MAPS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr]  <= wr_row;
      weight_r[wr_addr] <= wr_weight;
    end
    if (rd_en) begin
      rd_row <= row_mem[rd_addr];
    end
  end

  assign wt_data = weight_r[wt_addr];

endmodule

// ----- hdl/ifs_cg_mac.sv -----
// ifs_cg_mac: shared signed multiplier with accumulate, round and clamp.
// Uses ifs_cg_pkg (mac_ctrl_t, slots, FRAC_BITS).
module ifs_cg_mac #(
  parameter int WORD_WIDTH = 24
) (
  input  logic                                             clk,
  input  ifs_cg_pkg::mac_ctrl_t                            ctrl,
  input  logic [ifs_cg_pkg::COEFS_PER_MAP*WORD_WIDTH-1:0]  coef_row,
  input  logic signed [WORD_WIDTH-1:0]                     point_x,
  input  logic signed [WORD_WIDTH-1:0]                     point_y,
  output logic signed [WORD_WIDTH-1:0]                     res_x,
  output logic signed [WORD_WIDTH-1:0]                     res_y,
  output logic                                             sat
);
  localparam int WW = WORD_WIDTH;
  localparam int FB = ifs_cg_pkg::FRAC_BITS;
  localparam int PW = 2 * WW;           // exact product
  localparam int SW = PW + 1;           // two products plus half
  localparam int TW = PW + 2 - FB;      // rounded sum plus offset
  localparam logic signed [SW-1:0] HALF = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  logic signed [WW-1:0] mul_a, mul_b, offset;
  logic signed [PW-1:0] prod_r, acc_r;
  logic signed [SW-1:0] sum_r;
  logic signed [TW-1:0] total;
  logic [TW-WW:0]       top_bits;
  logic                 in_range;
  logic signed [WW-1:0] clamped;
  logic signed [WW-1:0] res_x_r, res_y_r;
  logic                 sat_r;

  always_comb begin
    case (ctrl.mul_sel)
      ifs_cg_pkg::MSEL_XA: begin
        mul_a = coef_row[ifs_cg_pkg::SLOT_XA*WW +: WW];
        mul_b = point_x;
      end
      ifs_cg_pkg::MSEL_XB: begin
        mul_a = coef_row[ifs_cg_pkg::SLOT_XB*WW +: WW];
        mul_b = point_y;
      end
      ifs_cg_pkg::MSEL_YA: begin
        mul_a = coef_row[ifs_cg_pkg::SLOT_YA*WW +: WW];
        mul_b = point_x;
      end
      default: begin
        mul_a = coef_row[ifs_cg_pkg::SLOT_YB*WW +: WW];
        mul_b = point_y;
      end
    endcase
  end

  // floor((p1 + p2 + half) / 2^FB) + c, then clamp to the word range
  always_comb begin
    offset   = ctrl.fin_y ? coef_row[ifs_cg_pkg::SLOT_YC*WW +: WW]
                          : coef_row[ifs_cg_pkg::SLOT_XC*WW +: WW];
    total    = TW'($signed(sum_r[SW-1:FB])) + TW'(offset);
    top_bits = total[TW-1:WW-1];
    in_range = (&top_bits) || !(|top_bits);
    clamped  = in_range ? total[WW-1:0]
                        : {total[TW-1], {(WW-1){~total[TW-1]}}};
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
    end
    if (ctrl.acc_ld) begin
      acc_r <= prod_r;
    end
    if (ctrl.acc_add) begin
      sum_r <= SW'(acc_r) + SW'(prod_r) + HALF;
    end
    if (ctrl.fin) begin
      if (ctrl.fin_y) begin
        res_y_r <= clamped;
        sat_r   <= sat_r | !in_range;
      end else begin
        res_x_r <= clamped;
        sat_r   <= !in_range;
      end
    end
  end

  assign res_x = res_x_r;
  assign res_y = res_y_r;
  assign sat   = sat_r;

endmodule
